>>> rtl/core/ist_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the interval set table
// no dependencies
package ist_pkg;

  localparam int MAX_RANGES = 64;
  localparam int VAL_W      = 31;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int ADDR_W     = IDX_W + 1;
  // holds up to MAX_RANGES + 2 scratch entries
  localparam int CNT_W      = $clog2(MAX_RANGES + 3);
  localparam int SUM_W      = 32;

  typedef enum logic [2:0] {
    ACT_ADD       = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_HAS_VALUE = 3'd2,
    ACT_HAS_RANGE = 3'd3,
    ACT_OVERLAPS  = 3'd4,
    ACT_SPLIT     = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_EVAL,
    S_EVAL2,
    S_FLUSH,
    S_COMMIT,
    S_DONE
  } state_t;

  // one scratch entry offered to the merge stage, plus stage control
  typedef struct packed {
    logic             clr;
    logic             vld;
    logic             mrg;
    logic             flush;
    logic [VAL_W-1:0] s;
    logic [VAL_W-1:0] e;
  } cand_t;

endpackage

>>> rtl/core/ist_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces
// depends on ist_pkg
interface ist_req_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                action;
  logic [ist_pkg::VAL_W-1:0] range_start;
  logic [ist_pkg::VAL_W-1:0] range_end;
  modport source (output valid, action, range_start, range_end, input ready);
  modport sink (input valid, action, range_start, range_end, output ready);
endinterface

interface ist_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [6:0]  range_count;
  logic [31:0] covered_total;
  modport source (output valid, status, hit, range_count, covered_total, input ready);
  modport sink (input valid, status, hit, range_count, covered_total, output ready);
endinterface

>>> rtl/core/ist_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram, registered read
// no dependencies
module ist_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/ist_merge.sv
`timescale 1ns / 1ps
// merge stage: folds touching entries (unless cand.mrg is low) and writes the new table
// depends on ist_pkg
module ist_merge (
  input  logic                         clk,
  input  logic                         rst,
  input  ist_pkg::cand_t               cand,
  output logic                         we,
  output logic [ist_pkg::IDX_W-1:0]    widx,
  output logic [ist_pkg::VAL_W-1:0]    ws,
  output logic [ist_pkg::VAL_W-1:0]    wend,
  output logic [ist_pkg::CNT_W-1:0]    count,
  output logic [ist_pkg::SUM_W-1:0]    sum
);
  logic                      pv;
  logic [ist_pkg::VAL_W-1:0] ps;
  logic [ist_pkg::VAL_W-1:0] pe;
  logic                      join_ok;
  logic                      emit;
  logic [ist_pkg::SUM_W-1:0] len;

  always_comb begin
    join_ok = pv && cand.mrg &&
              (({1'b0, pe} + 32'd1) >= {1'b0, cand.s});
    emit    = pv && ((cand.vld && !join_ok) || cand.flush);
    len     = {1'b0, pe} - {1'b0, ps} + 32'd1;
    we      = emit && (count < ist_pkg::CNT_W'(ist_pkg::MAX_RANGES));
    widx    = count[ist_pkg::IDX_W-1:0];
    ws      = ps;
    wend    = pe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv    <= 1'b0;
      count <= '0;
      sum   <= '0;
    end else if (cand.clr) begin
      pv    <= 1'b0;
      count <= '0;
      sum   <= '0;
    end else begin
      if (emit) begin
        count <= count + 1'b1;
        sum   <= sum + len;
      end
      if (cand.vld) begin
        if (join_ok) begin
          if (cand.e > pe) begin
            pe <= cand.e;
          end
        end else begin
          ps <= cand.s;
          pe <= cand.e;
          pv <= 1'b1;
        end
      end else if (cand.flush) begin
        pv <= 1'b0;
      end
    end
  end
endmodule

>>> rtl/core/interval_set_table_unit.sv
`timescale 1ns / 1ps
// interval set table: sorted disjoint ranges with add, remove, queries, split
// depends on ist_pkg, ist_if, ist_ram, ist_merge
//
//  channel  dir  payload
//  req      in   action, range_start, range_end
//  rsp      out  status, hit, range_count, covered_total
//
// one word at a time: req is taken only in idle, rsp is held until taken
// each well-formed item walks the table once, reading and then evaluating each entry,
// with an extra step for the entry that is cut or placed in front of; the
// ram read address shared by both rams paces the walk
// the table lives in two banks; add, remove and split write the other bank
// through the merge stage and flip banks only when the result fits
// synchronous active high reset empties the table; no clearing pass needed
module interval_set_table_unit (
  input logic           clk,
  input logic           rst,
  ist_req_if.sink       req,
  ist_rsp_if.source     rsp
);
  ist_pkg::state_t state, state_next;

  // captured item
  logic [2:0]                act, act_next;
  logic [ist_pkg::VAL_W-1:0] rs_in, rs_in_next;
  logic [ist_pkg::VAL_W-1:0] re_in, re_in_next;

  // walk and table state
  logic [ist_pkg::CNT_W-1:0] idx, idx_next;
  logic [ist_pkg::CNT_W-1:0] entry_total, entry_total_next;
  logic [ist_pkg::SUM_W-1:0] total, total_next;
  logic                      bank, bank_next;
  logic                      placed, placed_next;
  logic                      hit, hit_next;
  logic [1:0]                status, status_next;

  // ram and merge stage wiring
  ist_pkg::cand_t            cand;
  logic                      m_we;
  logic [ist_pkg::IDX_W-1:0] m_widx;
  logic [ist_pkg::VAL_W-1:0] m_ws;
  logic [ist_pkg::VAL_W-1:0] m_we_val;
  logic [ist_pkg::CNT_W-1:0] m_count;
  logic [ist_pkg::SUM_W-1:0] m_sum;
  logic [ist_pkg::ADDR_W-1:0] raddr;
  logic [ist_pkg::ADDR_W-1:0] waddr;
  logic [ist_pkg::VAL_W-1:0] rd_s;
  logic [ist_pkg::VAL_W-1:0] rd_e;

  logic uses_range;
  logic last;

  assign raddr = {bank, idx[ist_pkg::IDX_W-1:0]};
  assign waddr = {~bank, m_widx};

  ist_ram #(.WIDTH(ist_pkg::VAL_W), .DEPTH(2 * ist_pkg::MAX_RANGES)) u_starts (
    .clk(clk), .we(m_we), .waddr(waddr), .wdata(m_ws), .raddr(raddr), .rdata(rd_s)
  );

  ist_ram #(.WIDTH(ist_pkg::VAL_W), .DEPTH(2 * ist_pkg::MAX_RANGES)) u_ends (
    .clk(clk), .we(m_we), .waddr(waddr), .wdata(m_we_val), .raddr(raddr), .rdata(rd_e)
  );

  ist_merge u_merge (
    .clk(clk), .rst(rst), .cand(cand), .we(m_we), .widx(m_widx),
    .ws(m_ws), .wend(m_we_val), .count(m_count), .sum(m_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ist_pkg::S_IDLE;
      entry_total <= '0;
      total       <= '0;
      bank        <= 1'b0;
      idx         <= '0;
      placed      <= 1'b0;
      hit         <= 1'b0;
      status      <= ist_pkg::ST_DONE;
    end else begin
      state       <= state_next;
      entry_total <= entry_total_next;
      total       <= total_next;
      bank        <= bank_next;
      idx         <= idx_next;
      placed      <= placed_next;
      hit         <= hit_next;
      status      <= status_next;
    end
    act   <= act_next;
    rs_in <= rs_in_next;
    re_in <= re_in_next;
  end

  always_comb begin
    state_next       = state;
    act_next         = act;
    rs_in_next       = rs_in;
    re_in_next       = re_in;
    idx_next         = idx;
    entry_total_next = entry_total;
    total_next       = total;
    bank_next        = bank;
    placed_next      = placed;
    hit_next         = hit;
    status_next      = status;
    cand             = '0;
    cand.mrg         = (act != ist_pkg::ACT_SPLIT);
    uses_range       = (act == ist_pkg::ACT_ADD) || (act == ist_pkg::ACT_REMOVE) ||
                       (act == ist_pkg::ACT_HAS_RANGE) || (act == ist_pkg::ACT_OVERLAPS);
    last             = ((idx + 1'b1) == entry_total);
    req.ready        = (state == ist_pkg::S_IDLE);
    rsp.valid        = (state == ist_pkg::S_DONE);

    case (state)
      ist_pkg::S_IDLE: begin
        if (req.valid) begin
          act_next   = req.action;
          rs_in_next = req.range_start;
          re_in_next = req.range_end;
          state_next = ist_pkg::S_START;
        end
      end
      ist_pkg::S_START: begin
        idx_next    = '0;
        placed_next = 1'b0;
        hit_next    = 1'b0;
        status_next = ist_pkg::ST_DONE;
        cand.clr    = 1'b1;
        if (uses_range && (rs_in > re_in)) begin
          status_next = ist_pkg::ST_INVALID;
          state_next  = ist_pkg::S_DONE;
        end else if (act > ist_pkg::ACT_SPLIT) begin
          state_next = ist_pkg::S_DONE;
        end else if (entry_total == '0) begin
          state_next = ist_pkg::S_FLUSH;
        end else begin
          state_next = ist_pkg::S_READ;
        end
      end
      // ram data for idx shows up in the next cycle
      ist_pkg::S_READ: begin
        state_next = ist_pkg::S_EVAL;
      end
      ist_pkg::S_EVAL: begin
        state_next = last ? ist_pkg::S_FLUSH : ist_pkg::S_READ;
        idx_next   = idx + 1'b1;
        case (act)
          ist_pkg::ACT_ADD: begin
            cand.vld = 1'b1;
            if (!placed && (rd_s >= rs_in)) begin
              // new range goes in front of this entry
              cand.s      = rs_in;
              cand.e      = re_in;
              placed_next = 1'b1;
              state_next  = ist_pkg::S_EVAL2;
              idx_next    = idx;
            end else begin
              cand.s = rd_s;
              cand.e = rd_e;
            end
          end
          ist_pkg::ACT_REMOVE: begin
            if ((re_in < rd_s) || (rs_in > rd_e)) begin
              cand.vld = 1'b1;
              cand.s   = rd_s;
              cand.e   = rd_e;
            end else if (rd_s < rs_in) begin
              // left piece, right piece follows when it exists
              cand.vld = 1'b1;
              cand.s   = rd_s;
              cand.e   = rs_in - 1'b1;
              if (rd_e > re_in) begin
                state_next = ist_pkg::S_EVAL2;
                idx_next   = idx;
              end
            end else if (rd_e > re_in) begin
              cand.vld = 1'b1;
              cand.s   = re_in + 1'b1;
              cand.e   = rd_e;
            end
          end
          ist_pkg::ACT_HAS_VALUE: begin
            if ((rd_s <= rs_in) && (rs_in <= rd_e)) begin
              hit_next = 1'b1;
            end
          end
          ist_pkg::ACT_HAS_RANGE: begin
            if ((rd_s <= rs_in) && (rs_in <= rd_e) && (rd_e >= re_in)) begin
              hit_next = 1'b1;
            end
          end
          ist_pkg::ACT_OVERLAPS: begin
            if ((rd_s <= re_in) && (rs_in <= rd_e)) begin
              hit_next = 1'b1;
            end
          end
          ist_pkg::ACT_SPLIT: begin
            cand.vld = 1'b1;
            cand.s   = rd_s;
            if ((rd_s < rs_in) && (rs_in <= rd_e)) begin
              cand.e     = rs_in - 1'b1;
              hit_next   = 1'b1;
              state_next = ist_pkg::S_EVAL2;
              idx_next   = idx;
            end else begin
              cand.e = rd_e;
            end
          end
          default: begin
          end
        endcase
      end
      // second scratch entry from the same table entry
      ist_pkg::S_EVAL2: begin
        state_next = last ? ist_pkg::S_FLUSH : ist_pkg::S_READ;
        idx_next   = idx + 1'b1;
        cand.vld   = 1'b1;
        cand.e     = rd_e;
        case (act)
          ist_pkg::ACT_ADD:    cand.s = rd_s;
          ist_pkg::ACT_REMOVE: cand.s = re_in + 1'b1;
          default:             cand.s = rs_in;
        endcase
      end
      ist_pkg::S_FLUSH: begin
        if ((act == ist_pkg::ACT_ADD) && !placed) begin
          cand.vld    = 1'b1;
          cand.s      = rs_in;
          cand.e      = re_in;
          placed_next = 1'b1;
        end else begin
          cand.flush = 1'b1;
          state_next = ist_pkg::S_COMMIT;
        end
      end
      ist_pkg::S_COMMIT: begin
        state_next = ist_pkg::S_DONE;
        if ((act == ist_pkg::ACT_ADD) || (act == ist_pkg::ACT_REMOVE) ||
            ((act == ist_pkg::ACT_SPLIT) && hit)) begin
          if (m_count > ist_pkg::CNT_W'(ist_pkg::MAX_RANGES)) begin
            status_next = ist_pkg::ST_FULL;
            hit_next    = 1'b0;
          end else begin
            bank_next        = ~bank;
            entry_total_next = m_count;
            total_next       = m_sum;
          end
        end
      end
      ist_pkg::S_DONE: begin
        if (rsp.ready) begin
          state_next = ist_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ist_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp.status        = status;
  assign rsp.hit           = hit;
  assign rsp.range_count   = 7'(entry_total);
  assign rsp.covered_total = total;

`ifndef SYNTHESIS
  a_no_overlap_req_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("response pending while ready for a request");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("ready right after accept");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_total <= ist_pkg::CNT_W'(ist_pkg::MAX_RANGES)) else $error("entry count overflow");
  a_full_keeps_table: assert property (@(posedge clk) disable iff (rst)
    (state == ist_pkg::S_DONE && status == ist_pkg::ST_FULL) |-> $stable(bank))
    else $error("table changed on full");
`endif
endmodule
